// File: sv/array_insert_delete_search_assert.svh
// Assertion macros for the array_insert_delete_search RTL.
// Expects signals named clk and arst_n in the including module.
`ifndef ARRAY_INSERT_DELETE_SEARCH_ASSERT_SVH
`define ARRAY_INSERT_DELETE_SEARCH_ASSERT_SVH

// Property holds in every cycle out of reset.
`define AIDS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define AIDS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/aids_pkg.sv
// Package for array_insert_delete_search: sizes, opcodes, status codes,
// payload structs and controller/datapath interface types. No dependencies.
`timescale 1ns / 1ps

package aids_pkg;

	localparam int DEPTH       = 16;
	localparam int MAX_RESULTS = 16;
	localparam int IDX_W       = $clog2(DEPTH);
	localparam int CNT_W       = $clog2(DEPTH + 1);
	localparam int RES_W       = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;
	localparam int POS_W       = 4;
	localparam int CMP_W       = (CNT_W > POS_W) ? CNT_W : POS_W;

	localparam logic [2:0] OP_CLEAR  = 3'd0;
	localparam logic [2:0] OP_APPEND = 3'd1;
	localparam logic [2:0] OP_INSERT = 3'd2;
	localparam logic [2:0] OP_DELETE = 3'd3;
	localparam logic [2:0] OP_SEARCH = 3'd4;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	typedef struct packed {
		logic [2:0]         opcode;
		logic signed [31:0] value;
		logic [POS_W-1:0]   position;
	} req_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [4:0]         count;
		logic               found;
		logic [3:0]         match_index;
		logic signed [31:0] match_value;
		logic               last;
	} rsp_item_t;

	typedef enum logic {
		CS_IDLE,
		CS_SCAN
	} ctl_state_t;

	typedef struct packed {
		logic load_req;  // take request into holding register
		logic exec;      // execute held request
		logic step;      // emit next search result
		logic out_load;  // load result register
	} ctl_cmd_t;

	typedef struct packed {
		logic is_search;
		logic scan_last;
	} dp_stat_t;

endpackage

// File: sv/aids_ctrl.sv
// Controller for array_insert_delete_search: request holding flag, result
// valid flag and scan state machine. Depends on aids_pkg and the assert header.
`timescale 1ns / 1ps
`include "array_insert_delete_search_assert.svh"

module aids_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	input  aids_pkg::dp_stat_t stat,
	output aids_pkg::ctl_cmd_t cmd
);

	aids_pkg::ctl_state_t state_q, state_d;
	logic held_q;
	logic out_valid_q;
	logic out_free;

	assign out_free  = !out_valid_q || !rsp_stall;
	assign rsp_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			aids_pkg::CS_IDLE: begin
				if (held_q && out_free && stat.is_search) begin
					state_d = aids_pkg::CS_SCAN;
				end
			end
			aids_pkg::CS_SCAN: begin
				if (out_free && stat.scan_last) begin
					state_d = aids_pkg::CS_IDLE;
				end
			end
			default: state_d = aids_pkg::CS_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			aids_pkg::CS_IDLE: begin
				cmd.exec     = held_q && out_free;
				cmd.out_load = held_q && out_free && !stat.is_search;
			end
			aids_pkg::CS_SCAN: begin
				cmd.step     = out_free;
				cmd.out_load = out_free;
			end
			default: cmd = '0;
		endcase
		req_stall    = held_q && !cmd.exec;
		cmd.load_req = req_valid && !req_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= aids_pkg::CS_IDLE;
			held_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_req) begin
				held_q <= 1'b1;
			end else if (cmd.exec) begin
				held_q <= 1'b0;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`AIDS_ASSERT(a_no_overwrite, !(cmd.out_load && out_valid_q && rsp_stall), "result overwritten while stalled")
	`AIDS_ASSERT(a_no_exec_in_scan, !(state_q == aids_pkg::CS_SCAN && cmd.exec), "request executed during search scan")
	`AIDS_ASSERT_NEXT(a_last_ends_scan, cmd.step && stat.scan_last, state_q == aids_pkg::CS_IDLE, "scan did not end after last result")
	`AIDS_ASSERT_NEXT(a_exec_empties, cmd.exec && !cmd.load_req, !held_q, "holding register not released")

endmodule

// File: sv/aids_dp.sv
// Datapath for array_insert_delete_search: request register, element array,
// count, search match mask and result register. Depends on aids_pkg.
`timescale 1ns / 1ps

module aids_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  aids_pkg::ctl_cmd_t  cmd,
	input  aids_pkg::req_item_t req_data,
	output aids_pkg::dp_stat_t  stat,
	output aids_pkg::rsp_item_t rsp_data
);

	aids_pkg::req_item_t req_q;
	aids_pkg::rsp_item_t rsp_q;
	aids_pkg::rsp_item_t exec_rsp;
	aids_pkg::rsp_item_t scan_rsp;

	logic signed [31:0] entries_q [aids_pkg::DEPTH];
	logic signed [31:0] entries_d [aids_pkg::DEPTH];
	logic [aids_pkg::CNT_W-1:0] count_q, count_d;
	logic [aids_pkg::DEPTH-1:0] mask_q, mask_d;
	logic [aids_pkg::DEPTH-1:0] low_bit, rest;
	logic [aids_pkg::IDX_W-1:0] low_idx;
	logic [aids_pkg::RES_W-1:0] nres_q;
	logic signed [31:0] key_q;
	logic [aids_pkg::CMP_W-1:0] pos_x, cnt_x;
	logic [1:0] status_d;
	logic full, found;

	assign pos_x = aids_pkg::CMP_W'(req_q.position);
	assign cnt_x = aids_pkg::CMP_W'(count_q);
	assign full  = count_q >= aids_pkg::CNT_W'(aids_pkg::DEPTH);

	always_comb begin
		entries_d = entries_q;
		count_d   = count_q;
		status_d  = aids_pkg::ST_DONE;
		case (req_q.opcode)
			aids_pkg::OP_CLEAR: count_d = '0;
			aids_pkg::OP_APPEND: begin
				if (full) begin
					status_d = aids_pkg::ST_FULL;
				end else begin
					entries_d[count_q[aids_pkg::IDX_W-1:0]] = req_q.value;
					count_d = count_q + aids_pkg::CNT_W'(1);
				end
			end
			aids_pkg::OP_INSERT: begin
				if (full) begin
					status_d = aids_pkg::ST_FULL;
				end else if (pos_x > cnt_x) begin
					status_d = aids_pkg::ST_RANGE;
				end else begin
					for (int i = 1; i < aids_pkg::DEPTH; i++) begin
						if (aids_pkg::CMP_W'(i) > pos_x) begin
							entries_d[i] = entries_q[i-1];
						end
					end
					entries_d[req_q.position[aids_pkg::IDX_W-1:0]] = req_q.value;
					count_d = count_q + aids_pkg::CNT_W'(1);
				end
			end
			aids_pkg::OP_DELETE: begin
				if (pos_x >= cnt_x) begin
					status_d = aids_pkg::ST_RANGE;
				end else begin
					for (int i = 0; i < aids_pkg::DEPTH - 1; i++) begin
						if (aids_pkg::CMP_W'(i) >= pos_x) begin
							entries_d[i] = entries_q[i+1];
						end
					end
					count_d = count_q - aids_pkg::CNT_W'(1);
				end
			end
			default: status_d = aids_pkg::ST_DONE;
		endcase
	end

	// match vector of live entries, snapshot at search start
	always_comb begin
		for (int i = 0; i < aids_pkg::DEPTH; i++) begin
			mask_d[i] = (aids_pkg::CNT_W'(i) < count_q) && (entries_q[i] == req_q.value);
		end
	end

	assign low_bit = mask_q & (~mask_q + aids_pkg::DEPTH'(1));
	assign rest    = mask_q & ~low_bit;
	assign found   = |mask_q;

	always_comb begin
		low_idx = '0;
		for (int i = 0; i < aids_pkg::DEPTH; i++) begin
			low_idx = low_idx | ({aids_pkg::IDX_W{low_bit[i]}} & aids_pkg::IDX_W'(i));
		end
	end

	always_comb begin
		exec_rsp             = '0;
		exec_rsp.status      = status_d;
		exec_rsp.count       = 5'(count_d);
		exec_rsp.last        = 1'b1;
		scan_rsp             = '0;
		scan_rsp.status      = aids_pkg::ST_DONE;
		scan_rsp.count       = 5'(count_q);
		scan_rsp.found       = found;
		scan_rsp.match_index = found ? 4'(low_idx) : 4'd0;
		// a match holds the key itself
		scan_rsp.match_value = found ? key_q : 32'sd0;
		scan_rsp.last        = !found || (rest == '0)
			|| (nres_q == aids_pkg::RES_W'(aids_pkg::MAX_RESULTS - 1));
	end

	assign stat.is_search = req_q.opcode == aids_pkg::OP_SEARCH;
	assign stat.scan_last = scan_rsp.last;
	assign rsp_data       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			mask_q  <= '0;
			nres_q  <= '0;
		end else begin
			if (cmd.exec) begin
				count_q <= count_d;
				mask_q  <= mask_d;
				nres_q  <= '0;
			end else if (cmd.step) begin
				mask_q <= rest;
				nres_q <= nres_q + aids_pkg::RES_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q <= req_data;
		end
		if (cmd.exec) begin
			entries_q <= entries_d;
			key_q     <= req_q.value;
		end
		if (cmd.out_load) begin
			rsp_q <= cmd.step ? scan_rsp : exec_rsp;
		end
	end

endmodule

// File: sv/array_insert_delete_search.sv
// A request lands in a holding register and executes once the result register is
// free; its result is then loaded there. Clear, append, insert and delete sustain one
// request per cycle while the response is not stalled (the shift is combinational
// over a flop array). Search builds the match mask when it executes, then gives one
// result per cycle while the response is not stalled, paced by the single result register.
// Reset clears count and control state; array contents are undefined until written.
`timescale 1ns / 1ps

module array_insert_delete_search (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  aids_pkg::req_item_t req_data,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output aids_pkg::rsp_item_t rsp_data
);

	aids_pkg::ctl_cmd_t cmd;
	aids_pkg::dp_stat_t stat;

	aids_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	aids_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.req_data (req_data),
		.stat     (stat),
		.rsp_data (rsp_data)
	);

endmodule
